// ===== hw/rtl/iwu_pkg.sv =====
// ----------------------------------------------------------------------------
// iwu_pkg
// lattice sizes, field widths and direction codes for the worm update step
// ----------------------------------------------------------------------------
`default_nettype none

package iwu_pkg;

    // lattice is ROWS x COLS, both powers of two so a site is {row, col}
    localparam int ROWS  = 64;
    localparam int COLS  = 64;
    localparam int ROW_W = $clog2(ROWS);
    localparam int COL_W = $clog2(COLS);
    localparam int SITE_W = ROW_W + COL_W;
    localparam int BOND_W = SITE_W + 1;
    localparam int BONDS  = 2 * ROWS * COLS;

    localparam int DRAW_W   = 16;
    localparam int THR_W    = 17;
    localparam int OFFSET_W = 12;
    localparam int CNT_W    = 12;

    localparam logic [THR_W-1:0] THRESH_RESET = THR_W'(26214);
    localparam logic [CNT_W-1:0] COUNT_MAX    = {CNT_W{1'b1}};

    // neighbour direction codes
    localparam logic [1:0] DIR_ROW_DN = 2'd0;
    localparam logic [1:0] DIR_COL_UP = 2'd1;
    localparam logic [1:0] DIR_ROW_UP = 2'd2;
    localparam logic [1:0] DIR_COL_DN = 2'd3;

endpackage

`default_nettype wire

// ===== hw/rtl/ising_worm_update_step.sv =====
// ----------------------------------------------------------------------------
// ising_worm_update_step
// one worm move of the 2d ising worm algorithm on a periodic lattice
// ----------------------------------------------------------------------------
// Takes one move word per cycle unless in_ready is low (bond RAM clear, or
// a move held up by out_ready) and returns one result word per move, via
// the move stage and the result register. The bond lattice lives in a
// one-bit-wide single-write RAM; the move's bond is read when the word is
// taken and written back as the move leaves the move stage, with a bypass
// so back-to-back moves on the same bond see each other. After reset the
// block clears the bond RAM (in_ready low); threshold writes are taken
// meanwhile. The threshold may only be written while no move is in flight.
`default_nettype none

module ising_worm_update_step (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // threshold register
    input  wire logic                          cfg_we,
    input  wire logic [iwu_pkg::THR_W-1:0]     cfg_data,
    // move words
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [1:0]                    direction,
    input  wire logic [iwu_pkg::DRAW_W-1:0]    accept_draw,
    input  wire logic                          kick_coin,
    input  wire logic [iwu_pkg::OFFSET_W-1:0]  kick_offset,
    input  wire logic                          sweep_start,
    // result words
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [iwu_pkg::ROW_W-1:0]          tail_row,
    output logic [iwu_pkg::COL_W-1:0]          tail_col,
    output logic [iwu_pkg::ROW_W-1:0]          head_row,
    output logic [iwu_pkg::COL_W-1:0]          head_col,
    output logic                               accepted,
    output logic [iwu_pkg::BOND_W-1:0]         bond_index,
    output logic                               bond_now,
    output logic                               met,
    output logic                               kicked,
    output logic [iwu_pkg::CNT_W-1:0]          meet_count
);
    import iwu_pkg::*;

    // bond ram
    logic                bond_mem [BONDS];
    logic                rd_data_reg;
    logic                mem_we;
    logic [BOND_W-1:0]   mem_waddr;
    logic                mem_wdata;

    // clearing pass
    logic                clr_busy_reg;
    logic [BOND_W-1:0]   clr_cnt_reg;

    // committed walker state
    logic [ROW_W-1:0]    tail_row_reg, head_row_reg;
    logic [COL_W-1:0]    tail_col_reg, head_col_reg;
    logic [CNT_W-1:0]    meet_count_reg;
    logic [THR_W-1:0]    thr_reg;

    // move stage
    logic                s1_valid_reg;
    logic [ROW_W-1:0]    s1_nr_reg;
    logic [COL_W-1:0]    s1_nc_reg;
    logic [BOND_W-1:0]   s1_idx_reg;
    logic [DRAW_W-1:0]   s1_draw_reg;
    logic                s1_coin_reg;
    logic [OFFSET_W-1:0] s1_offset_reg;
    logic                s1_sweep_reg;
    logic                fwd_hit_reg;
    logic                fwd_val_reg;

    // result register
    logic                out_valid_reg;
    logic [ROW_W-1:0]    o_tail_row_reg, o_head_row_reg;
    logic [COL_W-1:0]    o_tail_col_reg, o_head_col_reg;
    logic                o_accepted_reg, o_bond_reg, o_met_reg, o_kicked_reg;
    logic [BOND_W-1:0]   o_idx_reg;
    logic [CNT_W-1:0]    o_count_reg;

    // move stage logic
    logic                bond_old, acc, bond_new, s1_adv, in_fire;
    logic [ROW_W-1:0]    tr_mv, tr_fin, hr_fin;
    logic [COL_W-1:0]    tc_mv, tc_fin, hc_fin;
    logic                met_c, kick_c;
    logic [CNT_W-1:0]    cnt_base, cnt_new;
    logic [SITE_W-1:0]   kick_site;

    // address logic
    logic [ROW_W-1:0]    cur_r, nb_r, lo_r;
    logic [COL_W-1:0]    cur_c, nb_c, lo_c;
    logic [BOND_W-1:0]   idx_in;

    function automatic logic [SITE_W-1:0] kick_offset_ext(input logic [OFFSET_W-1:0] off);
        logic [SITE_W+OFFSET_W-1:0] wide;
        wide = (SITE_W+OFFSET_W)'(off);
        return wide[SITE_W-1:0];
    endfunction

    always_comb
    begin
        bond_old = fwd_hit_reg ? fwd_val_reg : rd_data_reg;
        acc      = bond_old | ({1'b0, s1_draw_reg} <= thr_reg);
        bond_new = bond_old ^ acc;
        tr_mv    = acc ? s1_nr_reg : tail_row_reg;
        tc_mv    = acc ? s1_nc_reg : tail_col_reg;
        met_c    = (tr_mv == head_row_reg) && (tc_mv == head_col_reg);
        kick_c   = met_c & s1_coin_reg;
        cnt_base = s1_sweep_reg ? '0 : meet_count_reg;
        cnt_new  = (met_c && cnt_base != COUNT_MAX) ? cnt_base + 1'b1 : cnt_base;
        // site count is a power of two, so the wrap is the carry drop
        kick_site = {head_row_reg, head_col_reg} + SITE_W'(kick_offset_ext(s1_offset_reg));
        if (kick_c)
        begin
            hr_fin = kick_site[SITE_W-1:COL_W];
            hc_fin = kick_site[COL_W-1:0];
            tr_fin = kick_site[SITE_W-1:COL_W];
            tc_fin = kick_site[COL_W-1:0];
        end
        else
        begin
            hr_fin = head_row_reg;
            hc_fin = head_col_reg;
            tr_fin = tr_mv;
            tc_fin = tc_mv;
        end
        s1_adv = s1_valid_reg && (!out_valid_reg || out_ready);
    end

    // neighbour and bond address of the incoming move, from the tail it will see
    always_comb
    begin
        cur_r = s1_adv ? tr_fin : tail_row_reg;
        cur_c = s1_adv ? tc_fin : tail_col_reg;
        nb_r  = cur_r;
        nb_c  = cur_c;
        unique case (direction)
            DIR_ROW_DN: nb_r = (cur_r == '0) ? ROW_W'(ROWS - 1) : cur_r - 1'b1;
            DIR_COL_UP: nb_c = (cur_c == COL_W'(COLS - 1)) ? '0 : cur_c + 1'b1;
            DIR_ROW_UP: nb_r = (cur_r == ROW_W'(ROWS - 1)) ? '0 : cur_r + 1'b1;
            DIR_COL_DN: nb_c = (cur_c == '0) ? COL_W'(COLS - 1) : cur_c - 1'b1;
            default:    nb_r = cur_r;
        endcase
        // bond sits at the site it points up from
        if (direction == DIR_ROW_DN || direction == DIR_COL_DN)
        begin
            lo_r = nb_r;
            lo_c = nb_c;
        end
        else
        begin
            lo_r = cur_r;
            lo_c = cur_c;
        end
        idx_in = {lo_r, lo_c, direction[0]};
    end

    assign in_ready = !clr_busy_reg && (!s1_valid_reg || s1_adv);
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        if (clr_busy_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = 1'b0;
        end
        else
        begin
            mem_we    = s1_adv && acc;
            mem_waddr = s1_idx_reg;
            mem_wdata = bond_new;
        end
    end

    // read returns the old value on a same-address write, bypass covers it
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bond_mem[mem_waddr] <= mem_wdata;
        end
        if (in_fire)
        begin
            rd_data_reg <= bond_mem[idx_in];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg   <= 1'b1;
            clr_cnt_reg    <= '0;
            tail_row_reg   <= '0;
            tail_col_reg   <= '0;
            head_row_reg   <= '0;
            head_col_reg   <= '0;
            meet_count_reg <= '0;
            thr_reg        <= THRESH_RESET;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == BOND_W'(BONDS - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (cfg_we)
            begin
                thr_reg <= cfg_data;
            end
            if (s1_adv)
            begin
                tail_row_reg   <= tr_fin;
                tail_col_reg   <= tc_fin;
                head_row_reg   <= hr_fin;
                head_col_reg   <= hc_fin;
                meet_count_reg <= cnt_new;
            end
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_nr_reg     <= nb_r;
            s1_nc_reg     <= nb_c;
            s1_idx_reg    <= idx_in;
            s1_draw_reg   <= accept_draw;
            s1_coin_reg   <= kick_coin;
            s1_offset_reg <= kick_offset;
            s1_sweep_reg  <= sweep_start;
            fwd_hit_reg   <= s1_adv && acc && (s1_idx_reg == idx_in);
            fwd_val_reg   <= bond_new;
        end
        if (s1_adv)
        begin
            o_tail_row_reg <= tr_fin;
            o_tail_col_reg <= tc_fin;
            o_head_row_reg <= hr_fin;
            o_head_col_reg <= hc_fin;
            o_accepted_reg <= acc;
            o_idx_reg      <= s1_idx_reg;
            o_bond_reg     <= bond_new;
            o_met_reg      <= met_c;
            o_kicked_reg   <= kick_c;
            o_count_reg    <= cnt_new;
        end
    end

    assign out_valid  = out_valid_reg;
    assign tail_row   = o_tail_row_reg;
    assign tail_col   = o_tail_col_reg;
    assign head_row   = o_head_row_reg;
    assign head_col   = o_head_col_reg;
    assign accepted   = o_accepted_reg;
    assign bond_index = o_idx_reg;
    assign bond_now   = o_bond_reg;
    assign met        = o_met_reg;
    assign kicked     = o_kicked_reg;
    assign meet_count = o_count_reg;

endmodule

`default_nettype wire

// ===== sim/ising_worm_update_step_check.sv =====
// ----------------------------------------------------------------------------
// ising_worm_update_step_check
// tracks the worm lattice from the accepted move words and checks each result
// ----------------------------------------------------------------------------
// Keeps its own copy of the bonds, the worm ends, the meet counter and the
// threshold. Every accepted move word is turned into an expected result word
// and queued. Every accepted result word is compared field by field with the
// oldest queued one.

module ising_worm_update_step_check (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [iwu_pkg::THR_W-1:0]     cfg_data,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [1:0]                    direction,
    input  logic [iwu_pkg::DRAW_W-1:0]    accept_draw,
    input  logic                          kick_coin,
    input  logic [iwu_pkg::OFFSET_W-1:0]  kick_offset,
    input  logic                          sweep_start,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [iwu_pkg::ROW_W-1:0]     tail_row,
    input  logic [iwu_pkg::COL_W-1:0]     tail_col,
    input  logic [iwu_pkg::ROW_W-1:0]     head_row,
    input  logic [iwu_pkg::COL_W-1:0]     head_col,
    input  logic                          accepted,
    input  logic [iwu_pkg::BOND_W-1:0]    bond_index,
    input  logic                          bond_now,
    input  logic                          met,
    input  logic                          kicked,
    input  logic [iwu_pkg::CNT_W-1:0]     meet_count,
    output int                            mismatch_count,
    output int                            pending_moves
);

    import iwu_pkg::*;

    typedef struct packed {
        logic [ROW_W-1:0]  tail_row;
        logic [COL_W-1:0]  tail_col;
        logic [ROW_W-1:0]  head_row;
        logic [COL_W-1:0]  head_col;
        logic              accepted;
        logic [BOND_W-1:0] bond_index;
        logic              bond_now;
        logic              met;
        logic              kicked;
        logic [CNT_W-1:0]  meet_count;
    } move_result_t;

    logic              bond_lattice [BONDS];
    logic [ROW_W-1:0]  worm_tail_row;
    logic [COL_W-1:0]  worm_tail_col;
    logic [ROW_W-1:0]  worm_head_row;
    logic [COL_W-1:0]  worm_head_col;
    logic [CNT_W-1:0]  meets_so_far;
    logic [THR_W-1:0]  threshold;
    move_result_t      expected_moves [$];
    move_result_t      oldest;

    function automatic move_result_t advance_worm(
        input logic [1:0]          dir,
        input logic [DRAW_W-1:0]   draw,
        input logic                coin,
        input logic [OFFSET_W-1:0] offset,
        input logic                sweep
    );
        logic [ROW_W-1:0]  next_row;
        logic [COL_W-1:0]  next_col;
        logic [SITE_W-1:0] low_site;
        logic [SITE_W-1:0] kick_site;
        logic [BOND_W-1:0] bond_sel;
        logic              bond_bit;
        move_result_t      r;

        next_row = worm_tail_row;
        next_col = worm_tail_col;
        if (sweep)
            meets_so_far = '0;

        // lattice sides are powers of two, so wrapping is plain overflow
        case (dir)
            DIR_ROW_DN: next_row = worm_tail_row - 1'b1;
            DIR_COL_UP: next_col = worm_tail_col + 1'b1;
            DIR_ROW_UP: next_row = worm_tail_row + 1'b1;
            default:    next_col = worm_tail_col - 1'b1;
        endcase

        // the bond hangs off the site it points up from
        if (dir == DIR_ROW_DN || dir == DIR_COL_DN)
            low_site = {next_row, next_col};
        else
            low_site = {worm_tail_row, worm_tail_col};
        bond_sel = {low_site, dir[0]};

        bond_bit = bond_lattice[bond_sel];
        r.accepted = bond_bit || (draw <= threshold);
        if (r.accepted)
        begin
            bond_bit = ~bond_bit;
            bond_lattice[bond_sel] = bond_bit;
            worm_tail_row = next_row;
            worm_tail_col = next_col;
        end

        r.met = (worm_tail_row == worm_head_row) && (worm_tail_col == worm_head_col);
        r.kicked = 1'b0;
        if (r.met)
        begin
            if (meets_so_far != COUNT_MAX)
                meets_so_far = meets_so_far + 1'b1;
            if (coin)
            begin
                kick_site = {worm_head_row, worm_head_col} + SITE_W'(offset);
                worm_head_row = kick_site[SITE_W-1:COL_W];
                worm_head_col = kick_site[COL_W-1:0];
                worm_tail_row = worm_head_row;
                worm_tail_col = worm_head_col;
                r.kicked = 1'b1;
            end
        end

        r.tail_row   = worm_tail_row;
        r.tail_col   = worm_tail_col;
        r.head_row   = worm_head_row;
        r.head_col   = worm_head_col;
        r.bond_index = bond_sel;
        r.bond_now   = bond_bit;
        r.meet_count = meets_so_far;
        return r;
    endfunction

    function automatic void check_field(
        input string       name,
        input int unsigned want,
        input int unsigned got
    );
        if (want != got)
        begin
            mismatch_count++;
            $display("%0t %s: expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (bond_lattice[i])
                bond_lattice[i] = 1'b0;
            worm_tail_row = '0;
            worm_tail_col = '0;
            worm_head_row = '0;
            worm_head_col = '0;
            meets_so_far  = '0;
            threshold     = THRESH_RESET;
            expected_moves.delete();
            mismatch_count = 0;
            pending_moves <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_moves.insert(expected_moves.size(),
                                      advance_worm(direction, accept_draw, kick_coin,
                                                   kick_offset, sweep_start));
            if (out_valid && out_ready)
            begin
                if (expected_moves.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t result word with no move outstanding: %s %0d,%0d",
                             $time, "expected none, actual tail", tail_row, tail_col);
                end
                else
                begin
                    oldest = expected_moves.pop_front();
                    check_field("tail_row",   oldest.tail_row,   tail_row);
                    check_field("tail_col",   oldest.tail_col,   tail_col);
                    check_field("head_row",   oldest.head_row,   head_row);
                    check_field("head_col",   oldest.head_col,   head_col);
                    check_field("accepted",   oldest.accepted,   accepted);
                    check_field("bond_index", oldest.bond_index, bond_index);
                    check_field("bond_now",   oldest.bond_now,   bond_now);
                    check_field("met",        oldest.met,        met);
                    check_field("kicked",     oldest.kicked,     kicked);
                    check_field("meet_count", oldest.meet_count, meet_count);
                end
            end
            if (cfg_we)
                threshold = cfg_data;
            pending_moves <= expected_moves.size();
        end
    end

endmodule

// ===== sim/ising_worm_update_step_test.sv =====
// ----------------------------------------------------------------------------
// ising_worm_update_step_test
// stimulus and verdict for the worm update step
// ----------------------------------------------------------------------------
// Starts with rejected moves at the head so every move is a meet, runs a
// short directed walk over the lattice edges, kicks and sweeps, then runs
// random phases under different thresholds and idling patterns. Most random
// moves form small closed loops so the worm keeps returning to its head.

module ising_worm_update_step_test;

    import iwu_pkg::*;

    localparam int CYCLE_LIMIT   = 500_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int COUNT_FILL    = 60;
    localparam int PHASE_MOVES   = 85;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 cfg_we      = 1'b0;
    logic [THR_W-1:0]     cfg_data    = '0;
    logic                 in_valid    = 1'b0;
    logic                 in_ready;
    logic [1:0]           direction   = '0;
    logic [DRAW_W-1:0]    accept_draw = '0;
    logic                 kick_coin   = 1'b0;
    logic [OFFSET_W-1:0]  kick_offset = '0;
    logic                 sweep_start = 1'b0;
    logic                 out_valid;
    logic                 out_ready   = 1'b1;
    logic [ROW_W-1:0]     tail_row;
    logic [COL_W-1:0]     tail_col;
    logic [ROW_W-1:0]     head_row;
    logic [COL_W-1:0]     head_col;
    logic                 accepted;
    logic [BOND_W-1:0]    bond_index;
    logic                 bond_now;
    logic                 met;
    logic                 kicked;
    logic [CNT_W-1:0]     meet_count;

    int                   mismatch_count;
    int                   pending_moves;
    int                   sender_idle_pct    = 0;
    int                   receiver_stall_pct = 0;
    int                   cycle_count        = 0;
    int                   moves_offered      = 0;
    logic [THR_W-1:0]     cur_thr            = THRESH_RESET;

    ising_worm_update_step u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .direction   (direction),
        .accept_draw (accept_draw),
        .kick_coin   (kick_coin),
        .kick_offset (kick_offset),
        .sweep_start (sweep_start),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .tail_row    (tail_row),
        .tail_col    (tail_col),
        .head_row    (head_row),
        .head_col    (head_col),
        .accepted    (accepted),
        .bond_index  (bond_index),
        .bond_now    (bond_now),
        .met         (met),
        .kicked      (kicked),
        .meet_count  (meet_count)
    );

    ising_worm_update_step_check u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .direction      (direction),
        .accept_draw    (accept_draw),
        .kick_coin      (kick_coin),
        .kick_offset    (kick_offset),
        .sweep_start    (sweep_start),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .tail_row       (tail_row),
        .tail_col       (tail_col),
        .head_row       (head_row),
        .head_col       (head_col),
        .accepted       (accepted),
        .bond_index     (bond_index),
        .bond_now       (bond_now),
        .met            (met),
        .kicked         (kicked),
        .meet_count     (meet_count),
        .mismatch_count (mismatch_count),
        .pending_moves  (pending_moves)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);

    // holds the word until the edge that takes it
    task automatic offer_move(
        input logic [1:0]          dir,
        input logic [DRAW_W-1:0]   draw,
        input logic                coin,
        input logic [OFFSET_W-1:0] offset,
        input logic                sweep
    );
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        direction   <= dir;
        accept_draw <= draw;
        kick_coin   <= coin;
        kick_offset <= offset;
        sweep_start <= sweep;
        do
            @(posedge clk);
        while (!in_ready);
        moves_offered++;
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_moves != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_thr  = value;
    endtask

    function automatic int draw_cap();
        return (cur_thr > THR_W'(65535)) ? 65535 : int'(cur_thr);
    endfunction

    // a draw that always switches a clear bond on
    function automatic logic [DRAW_W-1:0] ok_draw();
        return DRAW_W'($urandom_range(0, draw_cap()));
    endfunction

    function automatic logic [DRAW_W-1:0] any_draw();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return DRAW_W'(draw_cap());
            3:       return DRAW_W'(draw_cap() + 1);
            default: return DRAW_W'($urandom);
        endcase
    endfunction

    function automatic logic [OFFSET_W-1:0] any_offset();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return OFFSET_W'($urandom);
        endcase
    endfunction

    task automatic offer_step(input logic [1:0] dir, input logic [DRAW_W-1:0] draw);
        offer_move(dir, draw, 1'($urandom), any_offset(), $urandom_range(0, 15) == 0);
    endtask

    // out along one axis, across, and back: closes on itself if all moves pass
    task automatic walk_loop();
        logic [1:0] leg_a;
        logic [1:0] leg_b;
        int         len_a;
        int         len_b;

        leg_a = 2'($urandom_range(0, 3));
        leg_b = leg_a ^ 2'b01;
        len_a = $urandom_range(1, 3);
        len_b = $urandom_range(0, 3);
        repeat (len_a) offer_step(leg_a, ($urandom_range(0, 9) == 0) ? any_draw() : ok_draw());
        repeat (len_b) offer_step(leg_b, ($urandom_range(0, 9) == 0) ? any_draw() : ok_draw());
        repeat (len_a) offer_step(leg_a ^ 2'b10, ok_draw());
        repeat (len_b) offer_step(leg_b ^ 2'b10, ok_draw());
    endtask

    task automatic run_phase(input logic [THR_W-1:0] thr, input int idle_pct, input int stall_pct);
        int start;

        wait_for_results();
        write_threshold(thr);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct <= stall_pct;
        start = moves_offered;
        while (moves_offered - start < PHASE_MOVES)
        begin
            if ($urandom_range(0, 99) < 75)
                walk_loop();
            else
                offer_step(2'($urandom_range(0, 3)), any_draw());
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // all bonds clear and tail on head: every rejected move is a meet
        repeat (COUNT_FILL)
            offer_move(2'($urandom_range(0, 3)),
                       DRAW_W'($urandom_range(int'(THRESH_RESET) + 1, 65535)),
                       1'b0, OFFSET_W'($urandom), 1'b0);

        offer_move(DIR_ROW_DN, '0, 1'b0, OFFSET_W'(5), 1'b0);
        offer_move(DIR_ROW_UP, '1, 1'b0, '0, 1'b0);
        // draw equal to the threshold, sweep clears the count
        offer_move(DIR_COL_DN, DRAW_W'(THRESH_RESET), 1'b0, '0, 1'b1);
        // meet with a kick of zero offset
        offer_move(DIR_COL_UP, '1, 1'b1, '0, 1'b0);
        // one above threshold is rejected, kick wraps to the last site
        offer_move(DIR_COL_UP, DRAW_W'(THRESH_RESET + 1), 1'b1, '1, 1'b0);
        offer_move(DIR_ROW_UP, '0, 1'b0, '0, 1'b1);
        offer_move(DIR_ROW_DN, '1, 1'b1, OFFSET_W'(1), 1'b0);
        offer_move(DIR_ROW_DN, '0, 1'b0, '0, 1'b0);
        offer_move(DIR_COL_DN, '0, 1'b0, '0, 1'b0);
        offer_move(DIR_COL_UP, '1, 1'b0, '0, 1'b0);
        offer_move(DIR_ROW_UP, '1, 1'b1, OFFSET_W'(2048), 1'b1);
        // rejected move at the head in a sweep-start word counts as one meet
        offer_move(DIR_ROW_UP, '1, 1'b0, '0, 1'b1);

        run_phase(THRESH_RESET, 0, 0);
        run_phase('0, 54, 0);
        run_phase(THR_W'(65536), 0, 54);
        run_phase('1, 14, 14);
        run_phase(THR_W'($urandom_range(0, 65536)), 0, 0);
        run_phase(THR_W'(1), 54, 0);
        run_phase(THR_W'(65535), 0, 54);
        run_phase(THR_W'($urandom_range(10000, 50000)), 14, 14);

        wait_for_results();
        if (mismatch_count == 0 && pending_moves == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/iwu_pkg.sv
hw/rtl/ising_worm_update_step.sv
sim/ising_worm_update_step_check.sv
sim/ising_worm_update_step_test.sv
